// ----- hdl/vln_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vln_pkg;

  // Number of root bits found by the square root chain.
  localparam int ROOT_BITS = 32;
  // Number of quotient bits found by the divide chain.
  localparam int QUOT_BITS = 31;
  // Number of vector components.
  localparam int NUM_COMP = 3;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic                             valid;
    logic [63:0]                      n;
    logic [33:0]                      rem;
    logic [ROOT_BITS-1:0]             root;
    logic [NUM_COMP-1:0][31:0]        mag;
    logic [NUM_COMP-1:0]              neg;
  } sqrt_t;

  // Data handed from one divide cell to the next.
  typedef struct packed {
    logic                             valid;
    logic [31:0]                      len;
    logic [NUM_COMP-1:0][31:0]        rem;
    logic [NUM_COMP-1:0][30:0]        dsh;
    logic [NUM_COMP-1:0][QUOT_BITS-1:0] quot;
    logic [NUM_COMP-1:0]              neg;
  } div_t;

endpackage
`default_nettype wire

// ----- hdl/vln_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vln_sqrt_cell
  import vln_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire sqrt_t d_in,
  output sqrt_t      d_out
);

  sqrt_t       d_r;
  sqrt_t       d_nxt;
  logic [35:0] shifted;
  logic [35:0] trial;

  // One bit of the root: bring in the next two radicand bits and try a one.
  always_comb begin
    shifted = {d_in.rem, d_in.n[63:62]};
    trial   = {2'b00, d_in.root, 2'b01};
    d_nxt   = d_in;
    d_nxt.n = {d_in.n[61:0], 2'b00};
    if (shifted >= trial) begin
      d_nxt.rem  = 34'(shifted - trial);
      d_nxt.root = {d_in.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      d_nxt.rem  = shifted[33:0];
      d_nxt.root = {d_in.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  // Hand the partial result to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_nxt.valid;
    end
    if (en) begin
      d_r.n    <= d_nxt.n;
      d_r.rem  <= d_nxt.rem;
      d_r.root <= d_nxt.root;
      d_r.mag  <= d_nxt.mag;
      d_r.neg  <= d_nxt.neg;
    end
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

// ----- hdl/vln_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vln_div_cell
  import vln_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire div_t d_in,
  output div_t      d_out
);

  div_t        d_r;
  div_t        d_nxt;
  logic [32:0] shifted [NUM_COMP];
  logic        ge      [NUM_COMP];

  // One quotient bit per component: restoring step against the length.
  always_comb begin
    d_nxt = d_in;
    for (int c = 0; c < NUM_COMP; c++) begin
      shifted[c] = {d_in.rem[c], d_in.dsh[c][30]};
      ge[c]      = shifted[c] >= {1'b0, d_in.len};
      if (ge[c]) begin
        d_nxt.rem[c] = 32'(shifted[c] - {1'b0, d_in.len});
      end else begin
        d_nxt.rem[c] = shifted[c][31:0];
      end
      d_nxt.dsh[c]  = {d_in.dsh[c][29:0], 1'b0};
      d_nxt.quot[c] = {d_in.quot[c][QUOT_BITS-2:0], ge[c]};
    end
  end

  // Hand the partial quotients to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_nxt.valid;
    end
    if (en) begin
      d_r.len  <= d_nxt.len;
      d_r.rem  <= d_nxt.rem;
      d_r.dsh  <= d_nxt.dsh;
      d_r.quot <= d_nxt.quot;
      d_r.neg  <= d_nxt.neg;
    end
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

// ----- hdl/vector3_length_normalize_core.sv -----
// Vector length and normalization core.
// The input channel (in_valid, in_ready) takes one vector of three signed
// Q16.16 components per request. The result channel (out_valid, out_ready)
// gives the truncated Euclidean length in unsigned Q16.16, the three unit
// components in signed Q2.30 truncated toward zero, and zero_length, which
// is set for the all-zero vector (its length and unit components are zero).
// A request passes through the magnitude register, the square register,
// the sum register, 32 square root cells (one root bit per cell), 31 divide
// cells (one quotient bit per cell for all three components) and the output
// register on its way to out_valid. Throughput is one request per cycle while
// the receiver does not stall; the whole pipeline moves in lock step and each
// cell holds one request.
// When the receiver stalls with a result waiting, the pipeline freezes and
// in_ready drops in the same cycle; in_ready is high whenever the output
// register is empty or being taken. Reset clears every valid bit, so the
// block comes out of reset empty and ready.
`timescale 1ns / 1ps
`default_nettype none
module vector3_length_normalize_core
  import vln_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_x_component,
  input  wire logic [31:0] in_y_component,
  input  wire logic [31:0] in_z_component,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_vector_length,
  output logic [31:0]      out_unit_x,
  output logic [31:0]      out_unit_y,
  output logic [31:0]      out_unit_z,
  output logic             out_zero_length
);

  logic                      en;
  logic [NUM_COMP-1:0][31:0] comp_in;
  logic [NUM_COMP-1:0][31:0] mag_nxt;
  logic [NUM_COMP-1:0]       neg_nxt;

  logic                      s0_valid_r;
  logic [NUM_COMP-1:0][31:0] s0_mag_r;
  logic [NUM_COMP-1:0]       s0_neg_r;
  logic                      s1_valid_r;
  logic [NUM_COMP-1:0][63:0] s1_sq_r;
  logic [NUM_COMP-1:0][31:0] s1_mag_r;
  logic [NUM_COMP-1:0]       s1_neg_r;
  logic [63:0]               sum_nxt;

  sqrt_t sq_chain [ROOT_BITS+1];
  div_t  dv_chain [QUOT_BITS+1];

  logic [NUM_COMP-1:0][31:0] unit_nxt;
  logic                      zero_nxt;
  logic                      out_valid_r;
  logic [31:0]               len_r;
  logic [NUM_COMP-1:0][31:0] unit_r;
  logic                      zero_r;

  // The whole pipeline advances unless a result waits on a stalled receiver.
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  // Magnitude and sign of each component.
  assign comp_in = {in_z_component, in_y_component, in_x_component};
  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      neg_nxt[c] = comp_in[c][31];
      mag_nxt[c] = comp_in[c][31] ? 32'(~comp_in[c] + 32'd1) : comp_in[c];
    end
  end

  // Input, square and sum stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
    end
    if (en) begin
      s0_mag_r <= mag_nxt;
      s0_neg_r <= neg_nxt;
      for (int c = 0; c < NUM_COMP; c++) begin
        s1_sq_r[c] <= 64'(s0_mag_r[c]) * 64'(s0_mag_r[c]);
      end
      s1_mag_r <= s0_mag_r;
      s1_neg_r <= s0_neg_r;
    end
  end

  assign sum_nxt = s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_chain[0].valid <= 1'b0;
    end else if (en) begin
      sq_chain[0].valid <= s1_valid_r;
    end
    if (en) begin
      sq_chain[0].n    <= sum_nxt;
      sq_chain[0].rem  <= '0;
      sq_chain[0].root <= '0;
      sq_chain[0].mag  <= s1_mag_r;
      sq_chain[0].neg  <= s1_neg_r;
    end
  end

  // Square root chain: one root bit per cell.
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    vln_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (sq_chain[i]),
      .d_out (sq_chain[i+1])
    );
  end

  // Seed the divide chain: the top dividend bits are below the length.
  always_comb begin
    dv_chain[0].valid = sq_chain[ROOT_BITS].valid;
    dv_chain[0].len   = sq_chain[ROOT_BITS].root;
    dv_chain[0].neg   = sq_chain[ROOT_BITS].neg;
    for (int c = 0; c < NUM_COMP; c++) begin
      dv_chain[0].rem[c]  = {1'b0, sq_chain[ROOT_BITS].mag[c][31:1]};
      dv_chain[0].dsh[c]  = {sq_chain[ROOT_BITS].mag[c][0], 30'd0};
      dv_chain[0].quot[c] = '0;
    end
  end

  // Divide chain: one quotient bit per cell.
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    vln_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (dv_chain[i]),
      .d_out (dv_chain[i+1])
    );
  end

  // Apply signs and force zeros for the zero vector.
  always_comb begin
    zero_nxt = dv_chain[QUOT_BITS].len == 32'd0;
    for (int c = 0; c < NUM_COMP; c++) begin
      if (zero_nxt) begin
        unit_nxt[c] = '0;
      end else if (dv_chain[QUOT_BITS].neg[c]) begin
        unit_nxt[c] = 32'(~{1'b0, dv_chain[QUOT_BITS].quot[c]} + 32'd1);
      end else begin
        unit_nxt[c] = {1'b0, dv_chain[QUOT_BITS].quot[c]};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_chain[QUOT_BITS].valid;
    end
    if (en) begin
      len_r  <= dv_chain[QUOT_BITS].len;
      unit_r <= unit_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vector_length = len_r;
  assign out_unit_x        = unit_r[0];
  assign out_unit_y        = unit_r[1];
  assign out_unit_z        = unit_r[2];
  assign out_zero_length   = zero_r;

endmodule
`default_nettype wire

// ----- hdl/vln_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vln_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_vector_length,
  input wire logic [31:0] out_unit_x,
  input wire logic [31:0] out_unit_y,
  input wire logic [31:0] out_unit_z,
  input wire logic        out_zero_length
);

  // A stalled result keeps its length.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vector_length))
    else $error("result changed while stalled");

  // The block takes a request whenever no result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("not ready while output empty");

  // The zero flag matches a zero length.
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_length == (out_vector_length == 32'd0)))
    else $error("zero flag does not match length");

  // A zero vector has zero unit components.
  a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_unit_x == 32'd0 && out_unit_y == 32'd0 && out_unit_z == 32'd0)
    else $error("zero vector with nonzero unit");

endmodule

bind vector3_length_normalize_core vln_checker u_vln_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_vector_length (out_vector_length),
  .out_unit_x        (out_unit_x),
  .out_unit_y        (out_unit_y),
  .out_unit_z        (out_unit_z),
  .out_zero_length   (out_zero_length)
);
`default_nettype wire

// ----- bench/vector3_length_normalize_core_test.sv -----
`timescale 1ns / 1ps
module vector3_length_normalize_core_test;

  // Latency of the block.
  localparam int PIPE_DEPTH = 67;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_COUNT = 450;

  // One result of the block.
  typedef struct packed {
    logic [31:0] len;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic        zero;
  } norm_t;

  // One row of directed stimulus; has_exp marks a hand-typed result.
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          has_exp;
    norm_t       exp;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_x_component;
  logic [31:0] in_y_component;
  logic [31:0] in_z_component;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_vector_length;
  logic [31:0] out_unit_x;
  logic [31:0] out_unit_y;
  logic [31:0] out_unit_z;
  logic        out_zero_length;

  norm_t       pending_norms[$];
  row_t        rows[$];
  int          fail_count;
  int          idle_pct;
  int          quiet_cycles;
  bit          timed_out;

  vector3_length_normalize_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_component   (in_x_component),
    .in_y_component   (in_y_component),
    .in_z_component   (in_z_component),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vector_length(out_vector_length),
    .out_unit_x       (out_unit_x),
    .out_unit_y       (out_unit_y),
    .out_unit_z       (out_unit_z),
    .out_zero_length  (out_zero_length)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Absolute value of a signed component, as 33 bits.
  function automatic logic [32:0] comp_mag(logic [31:0] v);
    return v[31] ? 33'h1_0000_0000 - {1'b0, v} : {1'b0, v};
  endfunction

  // Bit-by-bit integer square root of a 64-bit value, rounded down.
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Expected length and unit vector for one input vector.
  function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [32:0] m[3];
    logic [31:0] c[3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    logic [31:0] u[3];
    norm_t r;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = comp_mag(c[i]);
      sum = sum + {31'd0, m[i]} * {31'd0, m[i]};
    end
    len = floor_root(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        q = ({31'd0, m[i]} << 30) / len;
        if (c[i][31]) q = 64'd0 - q;
        u[i] = q[31:0];
      end
    end
    r.len = len[31:0];
    r.ux = u[0];
    r.uy = u[1];
    r.uz = u[2];
    r.zero = (len == 0);
    return r;
  endfunction

  function automatic row_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic row_t mk_exp(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  norm_t e);
    row_t r;
    r = mk(x, y, z);
    r.has_exp = 1'b1;
    r.exp = e;
    return r;
  endfunction

  // Random component: mostly full range, some small or extreme values.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 131072)) - 65536);
      4: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  // Send one vector, waiting for acceptance; random gaps before it.
  task automatic send_vector(row_t r);
    norm_t e;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    e = r.has_exp ? r.exp : normalize(r.x, r.y, r.z);
    in_valid <= 1'b1;
    in_x_component <= r.x;
    in_y_component <= r.y;
    in_z_component <= r.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_norms.push_back(e);
    @(negedge clk);
  endtask

  // Receiver stalls at random on each falling edge.
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    norm_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_norms.size() == 0) begin
        $error("unexpected result: length %0h", out_vector_length);
        fail_count++;
      end else begin
        e = pending_norms.pop_front();
        if (out_vector_length !== e.len) begin
          $error("vector_length expected %0h actual %0h", e.len, out_vector_length);
          fail_count++;
        end
        if (out_unit_x !== e.ux) begin
          $error("unit_x expected %0h actual %0h", e.ux, out_unit_x);
          fail_count++;
        end
        if (out_unit_y !== e.uy) begin
          $error("unit_y expected %0h actual %0h", e.uy, out_unit_y);
          fail_count++;
        end
        if (out_unit_z !== e.uz) begin
          $error("unit_z expected %0h actual %0h", e.uz, out_unit_z);
          fail_count++;
        end
        if (out_zero_length !== e.zero) begin
          $error("zero_length expected %0h actual %0h", e.zero, out_zero_length);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request accepted in either direction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      timed_out = 1'b1;
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_component = '0;
    in_y_component = '0;
    in_z_component = '0;
    out_ready = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    idle_pct = 27;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed vectors: zero vector, axis extremes, all-extreme corners, small and mixed vectors.
    rows.push_back(mk_exp(32'd0, 32'd0, 32'd0, '{0, 0, 0, 0, 1'b1}));
    rows.push_back(mk_exp(32'h0001_0000, 32'd0, 32'd0,
                          '{32'h0001_0000, 32'h4000_0000, 0, 0, 1'b0}));
    rows.push_back(mk_exp(32'd0, 32'hffff_0000, 32'd0,
                          '{32'h0001_0000, 0, 32'hc000_0000, 0, 1'b0}));
    rows.push_back(mk_exp(32'd0, 32'd0, 32'h8000_0000,
                          '{32'h8000_0000, 0, 0, 32'hc000_0000, 1'b0}));
    rows.push_back(mk_exp(32'h7fff_ffff, 32'd0, 32'd0,
                          '{32'h7fff_ffff, 32'h4000_0000, 0, 0, 1'b0}));
    rows.push_back(mk_exp(32'd1, 32'd0, 32'd0, '{32'd1, 32'h4000_0000, 0, 0, 1'b0}));
    rows.push_back(mk_exp(32'd0, 32'hffff_ffff, 32'd0,
                          '{32'd1, 0, 32'hc000_0000, 0, 1'b0}));
    rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    rows.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    rows.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    rows.push_back(mk(32'd1, 32'd1, 32'd1));
    rows.push_back(mk(32'hffff_ffff, 32'd1, 32'hffff_ffff));
    rows.push_back(mk(32'h0003_0000, 32'h0004_0000, 32'd0));
    rows.push_back(mk(32'hfffd_0000, 32'd0, 32'hfffc_0000));
    rows.push_back(mk(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f));
    rows.push_back(mk(32'd0, 32'd0, 32'd1));
    foreach (rows[i]) send_vector(rows[i]);

    // Random vectors; one long stretch with no idling on either side.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      idle_pct = (i >= 150 && i < 250) ? 0 : 27;
      send_vector(mk(rand_comp(), rand_comp(), rand_comp()));
    end
    in_valid <= 1'b0;
    idle_pct = 27;

    // Drain, then let the pipeline settle.
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
